/* rtl/event_flag_group_with_wait_queue_defines.svh */
// Assertion macros shared by the event flag group RTL.
`ifndef EVENT_FLAG_GROUP_WITH_WAIT_QUEUE_DEFINES_SVH
`define EVENT_FLAG_GROUP_WITH_WAIT_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define EFG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("efg assertion failed");
`define EFG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("efg assertion failed");
`else
`define EFG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define EFG_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/efg_pkg.sv */
// Shared constants and types of the event flag group.
package efg_pkg;
  localparam int EFG_QUEUE_DEPTH  = 16;
  localparam int EFG_PATTERN_BITS = 32;

  typedef enum logic [2:0] {
    CMD_SET     = 3'd0,
    CMD_CLEAR   = 3'd1,
    CMD_POLL    = 3'd2,
    CMD_WAIT    = 3'd3,
    CMD_CANCEL  = 3'd4,
    CMD_TIMEOUT = 3'd5,
    CMD_DELETE  = 3'd6
  } efg_cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_SAT   = 3'd1,
    STS_MULTI     = 3'd2,
    STS_QUEUED    = 3'd3,
    STS_CANCELLED = 3'd4,
    STS_TIMED_OUT = 3'd5,
    STS_DELETED   = 3'd6,
    STS_FULL      = 3'd7
  } efg_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REPLY,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_WAKE_RD,
    ST_WAKE_EMIT,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } efg_state_t;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;
  localparam logic REG_ALLOW  = 1'b0;
endpackage

/* rtl/efg_cmd_if.sv */
// Command channel carrying one item per handshake.
interface efg_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] pattern;
  logic [2:0]  wait_mode;
  logic [15:0] waiter_id;
  modport source (output valid, command, pattern, wait_mode, waiter_id, input ready);
  modport sink (input valid, command, pattern, wait_mode, waiter_id, output ready);
endinterface

/* rtl/efg_res_if.sv */
// Result channel carrying wakes and replies.
interface efg_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [15:0] result_waiter;
  logic [31:0] result_pattern;
  logic [4:0]  woken_count;
  logic        last;
  modport source (output valid, kind, status, result_waiter, result_pattern, woken_count,
                  last, input ready);
  modport sink (input valid, kind, status, result_waiter, result_pattern, woken_count,
                last, output ready);
endinterface

/* rtl/efg_wait_ram.sv */
// Waiter queue storage: one write port, one registered read port.
module efg_wait_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/event_flag_group_with_wait_queue.sv */
// Top level of the event flag group with its ordered wait queue.
// Each item ends with a reply, and every queued waiter visited adds a read state and a
// test or emit state: a walk tests one waiter at a time through the single match unit and
// the registered read of the queue memory; a timeout adds a search and a shift of the
// later entries, again one entry at a time. Poll, wait and unused codes visit no waiter.
// Reset clears the flag pattern, queue count, registers and output valid at once;
// queue entries are not cleared and are only read below the count.
`include "event_flag_group_with_wait_queue_defines.svh"
module event_flag_group_with_wait_queue #(
  parameter int QUEUE_DEPTH  = efg_pkg::EFG_QUEUE_DEPTH,
  parameter int PATTERN_BITS = efg_pkg::EFG_PATTERN_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  efg_cmd_if.sink     cmd,
  efg_res_if.source   res
);
  import efg_pkg::*;

  localparam int PW = PATTERN_BITS;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = 16 + PW + 3;

  efg_state_t state, state_next;
  logic [PW-1:0] flag, flag_next;
  logic [PW-1:0] init_pat;
  logic          allow;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] idx, idx_next;
  logic [2:0]    wstat, wstat_next;
  logic [2:0]    r_status, r_status_next;
  logic [15:0]   r_waiter, r_waiter_next;
  logic [PW-1:0] r_pat, r_pat_next;
  logic [4:0]    r_woken, r_woken_next;
  logic [15:0]   q_id, q_id_next;

  logic          emit;
  logic          e_kind, e_last;
  logic [2:0]    e_status;
  logic [15:0]   e_waiter;
  logic [PW-1:0] e_pat;
  logic [4:0]    e_woken;
  logic          ofree;

  logic          wr_en;
  logic [CW-1:0] wr_l, rd_l;
  logic [EW-1:0] wr_data, rdata;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   rd_id;
  logic [PW-1:0] rd_want;
  logic [2:0]    rd_mode;

  logic [PW-1:0] pin, cfg_pat;
  logic [PW-1:0] m_want, m_cons;
  logic [2:0]    m_mode;
  logic          m_hit;
  logic          cfg_wr;
  logic [PW+31:0] pin_ext, cfg_ext;
  logic [PW+31:0] out_ext, init_ext;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign pin_ext = {{PW{1'b0}}, cmd.pattern};
  assign pin     = pin_ext[PW-1:0];
  assign cfg_ext = {{PW{1'b0}}, pwdata};
  assign cfg_pat = cfg_ext[PW-1:0];

  assign rd_id   = rdata[EW-1 -: 16];
  assign rd_want = rdata[PW+2:3];
  assign rd_mode = rdata[2:0];

  // The single match unit, shared by poll, wait and the queue walk.
  assign m_want = (state == ST_IDLE) ? pin : rd_want;
  assign m_mode = (state == ST_IDLE) ? cmd.wait_mode : rd_mode;
  always_comb begin
    if (m_mode[0]) begin
      m_hit = |(m_want & flag);
    end else begin
      m_hit = ((m_want & flag) == m_want);
    end
    m_cons = m_mode[1] ? '0 : flag;
    if (m_mode[2]) begin
      m_cons = m_cons & ~m_want;
    end
  end

  assign waddr = phys(head, wr_l);
  assign raddr = phys(head, rd_l);

  efg_wait_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign ofree     = !res.valid || res.ready;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign init_ext  = {32'b0, init_pat};
  assign prdata    = (paddr[2] == REG_ALLOW) ? {31'b0, allow} : init_ext[31:0];

  always_comb begin
    state_next    = state;
    flag_next     = flag;
    count_next    = count;
    head_next     = head;
    idx_next      = idx;
    wstat_next    = wstat;
    r_status_next = r_status;
    r_waiter_next = r_waiter;
    r_pat_next    = r_pat;
    r_woken_next  = r_woken;
    q_id_next     = q_id;
    emit     = 1'b0;
    e_kind   = KIND_WAKE;
    e_status = STS_OK;
    e_waiter = '0;
    e_pat    = flag;
    e_woken  = '0;
    e_last   = 1'b0;
    wr_en    = 1'b0;
    wr_l     = count;
    wr_data  = {cmd.waiter_id, pin, cmd.wait_mode};
    rd_l     = idx;

    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          q_id_next     = cmd.waiter_id;
          r_waiter_next = '0;
          r_woken_next  = '0;
          r_status_next = STS_OK;
          r_pat_next    = flag;
          idx_next      = '0;
          case (cmd.command)
            CMD_SET: begin
              flag_next  = flag | pin;
              state_next = ST_WALK_RD;
            end
            CMD_CLEAR: begin
              flag_next  = flag & pin;
              state_next = ST_WALK_RD;
            end
            CMD_POLL: begin
              if (m_hit) begin
                flag_next = m_cons;
              end else begin
                r_status_next = STS_NOT_SAT;
              end
              state_next = ST_REPLY;
            end
            CMD_WAIT: begin
              r_waiter_next = cmd.waiter_id;
              if (m_hit) begin
                flag_next = m_cons;
              end else if (!allow && (count != '0)) begin
                r_status_next = STS_MULTI;
              end else if (count >= CW'(QUEUE_DEPTH)) begin
                r_status_next = STS_FULL;
              end else begin
                wr_en         = 1'b1;
                count_next    = count + 1'b1;
                r_status_next = STS_QUEUED;
              end
              state_next = ST_REPLY;
            end
            CMD_CANCEL: begin
              flag_next  = pin;
              wstat_next = STS_CANCELLED;
              state_next = ST_WAKE_RD;
            end
            CMD_TIMEOUT: begin
              r_waiter_next = cmd.waiter_id;
              state_next    = ST_SRCH_RD;
            end
            CMD_DELETE: begin
              wstat_next = STS_DELETED;
              state_next = ST_WAKE_RD;
            end
            default: begin
              state_next = ST_REPLY;
            end
          endcase
        end
      end
      ST_WALK_RD: begin
        rd_l = '0;
        if (count == '0) begin
          r_pat_next = flag;
          state_next = ST_REPLY;
        end else begin
          state_next = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        // Keep the head entry on the read port while the output is stalled.
        rd_l = '0;
        if (!m_hit) begin
          r_pat_next = flag;
          state_next = ST_REPLY;
        end else if (ofree) begin
          emit       = 1'b1;
          e_waiter   = rd_id;
          flag_next  = m_cons;
          head_next  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          count_next = count - 1'b1;
          state_next = ST_WALK_RD;
        end
      end
      ST_WAKE_RD: begin
        if (idx == count) begin
          r_woken_next = 5'(count);
          r_pat_next   = flag;
          count_next   = '0;
          state_next   = ST_REPLY;
        end else begin
          state_next = ST_WAKE_EMIT;
        end
      end
      ST_WAKE_EMIT: begin
        if (ofree) begin
          emit       = 1'b1;
          e_status   = wstat;
          e_waiter   = rd_id;
          idx_next   = idx + 1'b1;
          state_next = ST_WAKE_RD;
        end
      end
      ST_SRCH_RD: begin
        if (idx == count) begin
          r_status_next = STS_FULL;
          r_pat_next    = flag;
          state_next    = ST_REPLY;
        end else begin
          state_next = ST_SRCH_CHK;
        end
      end
      ST_SRCH_CHK: begin
        if (rd_id == q_id) begin
          if (ofree) begin
            emit       = 1'b1;
            e_status   = STS_TIMED_OUT;
            e_waiter   = q_id;
            state_next = ST_SHIFT_RD;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SRCH_RD;
        end
      end
      ST_SHIFT_RD: begin
        rd_l = CW'(idx + 1'b1);
        if (({1'b0, idx} + 1'b1) >= {1'b0, count}) begin
          count_next = count - 1'b1;
          state_next = ST_WALK_RD;
        end else begin
          state_next = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        // Close the gap left by the removed waiter, one entry at a time.
        wr_en      = 1'b1;
        wr_l       = idx;
        wr_data    = rdata;
        idx_next   = idx + 1'b1;
        state_next = ST_SHIFT_RD;
      end
      ST_REPLY: begin
        if (ofree) begin
          emit       = 1'b1;
          e_kind     = KIND_REPLY;
          e_status   = r_status;
          e_waiter   = r_waiter;
          e_pat      = r_pat;
          e_woken    = r_woken;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_wr && (paddr[2] != REG_ALLOW)) begin
      flag_next = cfg_pat;
    end
  end

  assign out_ext = {32'b0, e_pat};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flag      <= '0;
      count     <= '0;
      head      <= '0;
      allow     <= 1'b0;
      init_pat  <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      flag  <= flag_next;
      count <= count_next;
      head  <= head_next;
      if (cfg_wr) begin
        if (paddr[2] == REG_ALLOW) begin
          allow <= pwdata[0];
        end else begin
          init_pat <= cfg_pat;
        end
      end
      if (emit) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    wstat    <= wstat_next;
    r_status <= r_status_next;
    r_waiter <= r_waiter_next;
    r_pat    <= r_pat_next;
    r_woken  <= r_woken_next;
    q_id     <= q_id_next;
    if (emit) begin
      res.kind           <= e_kind;
      res.status         <= e_status;
      res.result_waiter  <= e_waiter;
      res.result_pattern <= out_ext[31:0];
      res.woken_count    <= e_woken;
      res.last           <= e_last;
    end
  end

  `EFG_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `EFG_ASSERT_IMP(a_no_overfill, clk, rst, wr_en && (state == ST_IDLE), count < CW'(QUEUE_DEPTH))
  `EFG_ASSERT_IMP(a_last_is_reply, clk, rst, res.valid, res.kind != res.last)
  `EFG_ASSERT_NXT(a_busy_after_item, clk, rst, cmd.valid && cmd.ready, state != ST_IDLE)
endmodule

/* sim/tb_event_flag_group_with_wait_queue.sv */
// Self-checking testbench of the event flag group with its ordered wait queue.
`timescale 1ns / 1ps
module tb_event_flag_group_with_wait_queue;
  import efg_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [15:0] waiter;
    logic [31:0] pattern;
    logic [4:0]  woken;
    logic        last;
  } outcome_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] want;
    logic [2:0]  mode;
  } waiter_t;

  localparam logic [2:0] ADDR_ALLOW   = 3'd0;
  localparam logic [2:0] ADDR_INITIAL = 3'd4;
  localparam logic [2:0] CMD_UNUSED   = 3'd7;
  localparam logic [2:0] MODE_ANY     = 3'd1;
  localparam logic [2:0] MODE_CLR_ALL = 3'd2;
  localparam logic [2:0] MODE_CLR_PAT = 3'd4;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  efg_cmd_if cmd ();
  efg_res_if res ();

  event_flag_group_with_wait_queue uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd.sink), .res(res.source)
  );

  // Predictor state.
  logic [31:0] flags;
  waiter_t     waiters[16];
  int          n_waiting;
  logic        allow_multi;

  outcome_t    expected_q[$];
  int          errors;
  int          n_results;
  int          n_items;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        holding;
  event        start_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  // Once started, the receiver hold-off keeps the result ready low until it ends by itself.
  initial begin
    holding = 1'b0;
    forever begin
      @(start_hold);
      holding = 1'b1;
      repeat (400) @(posedge clk);
      holding = 1'b0;
    end
  end

  function automatic logic matches_and_consume(input logic [31:0] want,
                                               input logic [2:0] mode);
    logic pass;
    if (mode & MODE_ANY) pass = (want & flags) != 0;
    else pass = (want & flags) == want;
    if (pass) begin
      if (mode & MODE_CLR_ALL) flags = '0;
      if (mode & MODE_CLR_PAT) flags = flags & ~want;
    end
    return pass;
  endfunction

  function automatic outcome_t mk(input logic kind, input logic [2:0] st,
                                  input logic [15:0] id, input logic [31:0] p,
                                  input logic [4:0] w, input logic lst);
    outcome_t o;
    o.kind = kind; o.status = st; o.waiter = id; o.pattern = p;
    o.woken = w; o.last = lst;
    return o;
  endfunction

  function automatic void queue_result(input outcome_t o);
    expected_q.insert(expected_q.size(), o);
  endfunction

  function automatic void drop_waiter(input int idx);
    for (int i = idx; i < n_waiting - 1; i++) waiters[i] = waiters[i + 1];
    n_waiting--;
  endfunction

  function automatic void walk_waiters();
    logic [31:0] prior;
    while (n_waiting > 0) begin
      prior = flags;
      if (!matches_and_consume(waiters[0].want, waiters[0].mode)) break;
      queue_result(mk(KIND_WAKE, STS_OK, waiters[0].id, prior, 5'd0, 1'b0));
      drop_waiter(0);
    end
  endfunction

  function automatic int release_all(input logic [2:0] st);
    int n;
    for (int i = 0; i < n_waiting; i++)
      queue_result(mk(KIND_WAKE, st, waiters[i].id, flags, 5'd0, 1'b0));
    n = n_waiting;
    n_waiting = 0;
    return n;
  endfunction

  function automatic void predict_command(input logic [2:0] c, input logic [31:0] p,
                                          input logic [2:0] mode, input logic [15:0] id);
    logic [31:0] prior;
    int          idx, n;
    case (c)
      CMD_SET, CMD_CLEAR: begin
        if (c == CMD_SET) flags = flags | p;
        else flags = flags & p;
        walk_waiters();
        queue_result(mk(KIND_REPLY, STS_OK, 16'd0, flags, 5'd0, 1'b1));
      end
      CMD_POLL: begin
        prior = flags;
        if (matches_and_consume(p, mode))
          queue_result(mk(KIND_REPLY, STS_OK, 16'd0, prior, 5'd0, 1'b1));
        else
          queue_result(mk(KIND_REPLY, STS_NOT_SAT, 16'd0, flags, 5'd0, 1'b1));
      end
      CMD_WAIT: begin
        prior = flags;
        if (matches_and_consume(p, mode))
          queue_result(mk(KIND_REPLY, STS_OK, id, prior, 5'd0, 1'b1));
        else if (!allow_multi && n_waiting > 0)
          queue_result(mk(KIND_REPLY, STS_MULTI, id, flags, 5'd0, 1'b1));
        else if (n_waiting >= EFG_QUEUE_DEPTH)
          queue_result(mk(KIND_REPLY, STS_FULL, id, flags, 5'd0, 1'b1));
        else begin
          waiters[n_waiting] = '{id: id, want: p, mode: mode};
          n_waiting++;
          queue_result(mk(KIND_REPLY, STS_QUEUED, id, flags, 5'd0, 1'b1));
        end
      end
      CMD_CANCEL: begin
        flags = p;
        n = release_all(STS_CANCELLED);
        queue_result(mk(KIND_REPLY, STS_OK, 16'd0, flags, 5'(n), 1'b1));
      end
      CMD_TIMEOUT: begin
        idx = -1;
        for (int i = n_waiting - 1; i >= 0; i--) if (waiters[i].id == id) idx = i;
        if (idx < 0)
          queue_result(mk(KIND_REPLY, STS_FULL, id, flags, 5'd0, 1'b1));
        else begin
          queue_result(mk(KIND_WAKE, STS_TIMED_OUT, id, flags, 5'd0, 1'b0));
          drop_waiter(idx);
          walk_waiters();
          queue_result(mk(KIND_REPLY, STS_OK, id, flags, 5'd0, 1'b1));
        end
      end
      CMD_DELETE: begin
        n = release_all(STS_DELETED);
        queue_result(mk(KIND_REPLY, STS_OK, 16'd0, flags, 5'(n), 1'b1));
      end
      default: queue_result(mk(KIND_REPLY, STS_OK, 16'd0, flags, 5'd0, 1'b1));
    endcase
  endfunction

  task automatic send_command(input logic [2:0] c, input logic [31:0] p,
                              input logic [2:0] mode, input logic [15:0] id);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    cmd.valid     <= 1'b1;
    cmd.command   <= c;
    cmd.pattern   <= p;
    cmd.wait_mode <= mode;
    cmd.waiter_id <= id;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_command(c, p, mode, id);
    n_items++;
    cmd.valid <= 1'b0;
    // The block is busy in the cycle after an accepted item.
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_q.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_ALLOW) allow_multi = data[0];
    else flags = data;
  endtask

  // Result checker; the receiver stalls at random or during a long hold-off.
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = mk(res.kind, res.status, res.result_waiter, res.result_pattern,
                 res.woken_count, res.last);
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (holding) begin
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [31:0] rand_pattern();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    write_register(ADDR_ALLOW, 32'd1);
    write_register(ADDR_INITIAL, 32'hFFFF_FFFF);
    send_command(CMD_POLL, 32'hFFFF_FFFF, 3'd0, 16'd0);
    send_command(CMD_POLL, 32'h0000_00F0, MODE_ANY | MODE_CLR_PAT, 16'd0);
    send_command(CMD_POLL, 32'h0, MODE_ANY, 16'd0);
    send_command(CMD_POLL, 32'h0, 3'd0, 16'd0);
    send_command(CMD_POLL, 32'h1, MODE_CLR_ALL | MODE_CLR_PAT, 16'd0);
    send_command(CMD_WAIT, 32'h0000_0003, 3'd0, 16'hFFFF);
    send_command(CMD_WAIT, 32'h8000_0000, MODE_ANY | MODE_CLR_PAT, 16'h0001);
    send_command(CMD_WAIT, 32'h0, MODE_ANY, 16'h0001);
    send_command(CMD_SET, 32'h0000_0001, 3'd0, 16'd0);
    send_command(CMD_SET, 32'h8000_0002, 3'd0, 16'd0);
    send_command(CMD_TIMEOUT, 32'd0, 3'd0, 16'h0001);
    send_command(CMD_TIMEOUT, 32'd0, 3'd0, 16'h1234);
    send_command(CMD_CLEAR, 32'h0, 3'd0, 16'd0);
    send_command(CMD_WAIT, 32'h4, 3'd7, 16'h0002);
    send_command(CMD_CANCEL, 32'hA5A5_5A5A, 3'd0, 16'd0);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 3'd7, 16'hFFFF);
    write_register(ADDR_ALLOW, 32'd0);
    send_command(CMD_WAIT, 32'h0, MODE_ANY, 16'h0003);
    send_command(CMD_WAIT, 32'h0, MODE_ANY, 16'h0004);
    send_command(CMD_DELETE, 32'd0, 3'd0, 16'd0);
    write_register(ADDR_INITIAL, 32'h0);
  endtask

  // Fill the queue past its depth, with a timeout of a duplicated id.
  task automatic test_full_queue();
    write_register(ADDR_ALLOW, 32'd1);
    for (int i = 0; i < EFG_QUEUE_DEPTH + 2; i++)
      send_command(CMD_WAIT, 32'h1 << (i % 4), 3'd0, 16'(i % 12));
    send_command(CMD_TIMEOUT, 32'd0, 3'd0, 16'd3);
    send_command(CMD_SET, 32'h0000_000F, 3'd0, 16'd0);
    send_command(CMD_DELETE, 32'd0, 3'd0, 16'd0);
  endtask

  // Long receiver hold-off while commands keep coming, then a quiet pause.
  task automatic test_backpressure();
    -> start_hold;
    for (int i = 0; i < 12; i++)
      send_command(CMD_WAIT, 32'h1 << i, 3'd0, 16'(i + 100));
    send_command(CMD_SET, 32'h0000_0FFF, 3'd0, 16'd0);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [2:0]  c;
    logic [15:0] id;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 59) write_register(ADDR_ALLOW, 32'($urandom_range(1)));
      if (i % 80 == 40) write_register(ADDR_INITIAL, rand_pattern());
      case ($urandom_range(19))
        0, 1, 2, 3:     c = CMD_SET;
        4, 5:           c = CMD_CLEAR;
        6, 7:           c = CMD_POLL;
        8, 9, 10, 11, 12, 13: c = CMD_WAIT;
        14:             c = CMD_CANCEL;
        15, 16:         c = CMD_TIMEOUT;
        17:             c = CMD_DELETE;
        18:             c = CMD_UNUSED;
        default:        c = 3'($urandom_range(7));
      endcase
      if (c == CMD_TIMEOUT && n_waiting > 0 && $urandom_range(3) != 0)
        id = waiters[$urandom_range(n_waiting - 1)].id;
      else if ($urandom_range(3) == 0)
        id = 16'($urandom);
      else
        id = 16'($urandom_range(15));
      send_command(c, rand_pattern(), 3'($urandom_range(7)), id);
    end
  endtask

  initial begin
    errors = 0; n_results = 0; n_items = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    flags = '0; n_waiting = 0; allow_multi = 1'b0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cmd.valid = 1'b0; cmd.command = '0; cmd.pattern = '0;
    cmd.wait_mode = '0; cmd.waiter_id = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_backpressure();
    test_random(42);
    send_idle_pct = 53; recv_stall_pct = 0;
    test_random(42);
    send_idle_pct = 0; recv_stall_pct = 53;
    test_random(42);
    send_idle_pct = 9; recv_stall_pct = 9;
    test_random(42);
    drain();
    $display("Covered %0d commands and %0d results: all commands, full queue,", n_items,
             n_results);
    $display("timeouts, both register settings, long output back-pressure and idling.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
